@@ rtl/cesd_pkg.sv @@
package cesd_pkg;

  localparam logic [2:0] ModePlain = 3'd0;
  localparam logic [2:0] ModeEsc   = 3'd1;
  localparam logic [2:0] ModeHex   = 3'd2;
  localparam logic [2:0] ModeOct   = 3'd3;
  localparam logic [2:0] ModeDrop  = 3'd4;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharX         = 8'h78;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharSeven     = 8'h37;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
    logic       bad_escape;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  // {valid, character}
  function automatic logic [8:0] single_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      8'h22:   r = {1'b1, 8'd34};
      8'h27:   r = {1'b1, 8'd39};
      8'h5C:   r = {1'b1, 8'd92};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

@@ rtl/cesd_decode.sv @@
module cesd_decode import cesd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output res_pair_t  pair_o
);

  logic [2:0] mode_q, mode_d;
  logic [8:0] pv_q, pv_d;
  logic [1:0] dc_q, dc_d;

  logic [8:0] esc;
  logic [4:0] hv;
  logic [8:0] pv_hex, pv_oct;
  logic [1:0] dc_inc;
  logic       is_oct;
  logic       first_v;
  logic [7:0] first_b;
  logic       first_bad;
  logic       do_plain;
  logic       plain_v;
  logic       err;
  logic       done;

  assign esc    = single_escape(in_byte_i);
  assign hv     = hex_val(in_byte_i);
  assign is_oct = (in_byte_i >= CharZero) && (in_byte_i <= CharSeven);
  assign pv_hex = {pv_q[4:0], hv[3:0]};
  assign pv_oct = {pv_q[5:0], in_byte_i[2:0]};
  assign dc_inc = dc_q + 2'd1;

  always_comb begin
    mode_d    = mode_q;
    pv_d      = pv_q;
    dc_d      = dc_q;
    first_v   = 1'b0;
    first_b   = 8'd0;
    first_bad = 1'b0;
    do_plain  = 1'b0;
    err       = 1'b0;
    case (mode_q)
      ModeEsc: begin
        mode_d = ModePlain;
        if (esc[8]) begin
          first_v = 1'b1;
          first_b = esc[7:0];
        end else if (in_byte_i == CharX) begin
          if (end_of_string_i) begin
            first_v   = 1'b1;
            first_bad = 1'b1;
            err       = 1'b1;
          end else begin
            mode_d = ModeHex;
            pv_d   = 9'd0;
            dc_d   = 2'd0;
          end
        end else if (is_oct) begin
          pv_d = {6'd0, in_byte_i[2:0]};
          dc_d = 2'd1;
          if (end_of_string_i) begin
            first_v = 1'b1;
            first_b = {5'd0, in_byte_i[2:0]};
          end else begin
            mode_d = ModeOct;
          end
        end else begin
          first_v  = 1'b1;
          first_b  = CharBackslash;
          do_plain = 1'b1;
        end
      end
      ModeHex: begin
        if (hv[4]) begin
          pv_d = pv_hex;
          dc_d = dc_inc;
          if (dc_inc >= 2'd2 || end_of_string_i) begin
            first_v = 1'b1;
            first_b = pv_hex[7:0];
            mode_d  = ModePlain;
          end
        end else if (dc_q == 2'd0) begin
          first_v   = 1'b1;
          first_bad = 1'b1;
          err       = 1'b1;
          mode_d    = end_of_string_i ? ModePlain : ModeDrop;
        end else begin
          first_v  = 1'b1;
          first_b  = pv_q[7:0];
          do_plain = 1'b1;
        end
      end
      ModeOct: begin
        if (is_oct) begin
          pv_d = pv_oct;
          dc_d = dc_inc;
          if (dc_inc == 2'd3 || end_of_string_i) begin
            first_v = 1'b1;
            first_b = pv_oct[7:0];
            mode_d  = ModePlain;
          end
        end else begin
          first_v  = 1'b1;
          first_b  = pv_q[7:0];
          do_plain = 1'b1;
        end
      end
      ModeDrop: begin
        if (end_of_string_i) begin
          mode_d = ModePlain;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    plain_v = 1'b0;
    if (do_plain) begin
      if (in_byte_i == CharBackslash && !end_of_string_i) begin
        mode_d = ModeEsc;
      end else begin
        mode_d  = ModePlain;
        plain_v = 1'b1;
      end
    end

    if (end_of_string_i && mode_d != ModeDrop) begin
      mode_d = ModePlain;
    end
  end

  assign done = end_of_string_i || err;

  always_comb begin
    pair_o = '0;
    if (first_v && plain_v) begin
      pair_o.cnt            = 2'd2;
      pair_o.r0.out_byte    = first_b;
      pair_o.r0.bad_escape  = first_bad;
      pair_o.r1.out_byte    = in_byte_i;
      pair_o.r1.run_last    = 1'b1;
      pair_o.r1.string_done = done;
    end else if (first_v || plain_v) begin
      pair_o.cnt            = 2'd1;
      pair_o.r0.out_byte    = first_v ? first_b : in_byte_i;
      pair_o.r0.bad_escape  = first_v & first_bad;
      pair_o.r0.run_last    = 1'b1;
      pair_o.r0.string_done = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      pv_q   <= 9'd0;
      dc_q   <= 2'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pv_q   <= pv_d;
      dc_q   <= dc_d;
    end
  end

endmodule

@@ rtl/cesd_outq.sv @@
module cesd_outq import cesd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_pair_t pair_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_t      head_o
);

  res_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] head_q, tail_q, tail_d;
  logic [QueueAw:0]   count_q, count_d;
  logic [1:0]         n_push;
  logic               pop;

  assign n_push      = push_i ? pair_i.cnt : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[head_q];
  // room for a two-result item
  assign room_o      = (count_q <= (QueueAw+1)'(QueueDepth - 2));
  assign tail_d      = tail_q + QueueAw'(n_push);
  assign count_d     = count_q + (QueueAw+1)'(n_push) - (QueueAw+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[tail_q] <= pair_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[tail_q + QueueAw'(1)] <= pair_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_d;
      count_q <= count_d;
      if (pop) begin
        head_q <= head_q + QueueAw'(1);
      end
    end
  end

endmodule

@@ rtl/c_escape_sequence_decoder.sv @@
// C-style string unescaper. Takes one byte per cycle (in_valid_i/in_ready_o) and decodes
// single-letter escapes, \x with one or two hex digits and octal escapes of up to three
// digits; each input byte yields zero, one or two result bytes. A byte is decoded in the
// cycle it is accepted and its results are written to a four-entry result queue that
// feeds the output. Input rate is one byte per cycle while the queue has room for
// two results; bytes that produce two results (an unknown escape, or a hex or octal
// escape cut short by a plain byte) fill two queue entries, so a long run of them
// stalls the input. A \x with no hex digit gives one result with bad_escape_o and
// string_done_o set, and the remaining bytes of that string produce nothing.
module c_escape_sequence_decoder import cesd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic       bad_escape_o
);

  logic      accept;
  res_pair_t pair;
  res_t      head;

  assign accept = in_valid_i && in_ready_o;

  cesd_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_string_i(end_of_string_i),
    .pair_o         (pair)
  );

  cesd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .pair_i     (pair),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign out_byte_o    = head.out_byte;
  assign run_last_o    = head.run_last;
  assign string_done_o = head.string_done;
  assign bad_escape_o  = head.bad_escape;

endmodule

@@ rtl/cesd_checker.sv @@
module cesd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       end_of_string_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       string_done_o,
  input logic       bad_escape_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i)
      && $stable(end_of_string_i))
    else $error("input transfer dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(string_done_o) && $stable(bad_escape_o))
    else $error("output transfer dropped or changed while stalled");

  a_bad_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_escape_o |-> string_done_o && run_last_o)
    else $error("bad escape must end the string");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o)
    else $error("string end not on last result of its byte");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_escape_o |-> out_byte_o == 8'd0)
    else $error("bad escape result carries data");

endmodule

bind c_escape_sequence_decoder cesd_checker u_cesd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .in_byte_i      (in_byte_i),
  .end_of_string_i(end_of_string_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .run_last_o     (run_last_o),
  .string_done_o  (string_done_o),
  .bad_escape_o   (bad_escape_o)
);
